>>> rtl/eei_pkg.sv
// ----------------------------------------------------------------------------
// eei_pkg
// Shared types and constants for the extended Euclidean inverse block: the
// request and result items, the controller states and the command and status
// groups passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package eei_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int OPND_W     = 31;
  localparam int COEF_OUT_W = 32;
  localparam int STEP_W     = 6;
  localparam int BIT_CNT_W  = $clog2(OPND_W);

  typedef struct packed {
    logic [OPND_W-1:0] operand_a;
    logic [OPND_W-1:0] operand_b;
  } eei_request_t;

  typedef struct packed {
    logic [OPND_W-1:0]            final_remainder;
    logic [OPND_W-1:0]            previous_remainder;
    logic signed [COEF_OUT_W-1:0] coeff_s;
    logic signed [COEF_OUT_W-1:0] coeff_t;
    logic [STEP_W-1:0]            step_count;
  } eei_result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIVIDE,
    ST_ACCUM,
    ST_UPDATE,
    ST_DONE
  } eei_state_t;

  typedef struct packed {
    logic load;
    logic div_init;
    logic div_step;
    logic accum;
    logic update;
  } eei_cmd_t;

  typedef struct packed {
    logic rem_le_one;
    logic div_last;
  } eei_status_t;

endpackage

>>> rtl/eei_ctrl.sv
// ----------------------------------------------------------------------------
// eei_ctrl
// Controller state machine. It sequences each Euclid step through division,
// final product accumulation and the pair update, and flags the result cycle.
// ----------------------------------------------------------------------------
module eei_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  eei_pkg::eei_status_t status,
  output eei_pkg::eei_cmd_t    cmd,
  output logic                 busy,
  output logic                 done
);
  import eei_pkg::*;

  eei_state_t state;
  eei_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    done       = 1'b0;
    unique case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status.rem_le_one) begin
          state_next = ST_DONE;
        end else begin
          cmd.div_init = 1'b1;
          state_next   = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = ST_ACCUM;
        end
      end
      ST_ACCUM: begin
        cmd.accum  = 1'b1;
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_next = ST_CHECK;
      end
      ST_DONE: begin
        done       = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/eei_datapath.sv
// ----------------------------------------------------------------------------
// eei_datapath
// Remainder, s and t pairs with a bit-serial restoring divider. The quotient
// bits are registered and feed shift-add accumulators in the next cycle;
// these form the quotient's products with the newest s and t coefficients.
// ----------------------------------------------------------------------------
module eei_datapath (
  input  logic                  clk,
  input  eei_pkg::eei_request_t request,
  input  eei_pkg::eei_cmd_t     cmd,
  output eei_pkg::eei_status_t  status,
  output eei_pkg::eei_result_t  result
);
  import eei_pkg::*;

  logic [OPND_W-1:0]     r_old;
  logic [OPND_W-1:0]     r_new;
  logic [DATA_WIDTH-1:0] s_old;
  logic [DATA_WIDTH-1:0] s_new;
  logic [DATA_WIDTH-1:0] t_old;
  logic [DATA_WIDTH-1:0] t_new;
  logic [DATA_WIDTH-1:0] acc_s;
  logic [DATA_WIDTH-1:0] acc_t;
  logic [OPND_W-1:0]     rem;
  logic [OPND_W-1:0]     dvd;
  logic                  qbit;
  logic [BIT_CNT_W-1:0]  bit_cnt;
  logic [STEP_W-1:0]     steps;

  logic [OPND_W:0]       trial;
  logic [OPND_W:0]       diff;
  logic                  trial_ge;
  logic [DATA_WIDTH-1:0] acc_s_next;
  logic [DATA_WIDTH-1:0] acc_t_next;

  assign trial    = {rem, dvd[OPND_W-1]};
  assign diff     = trial - {1'b0, r_new};
  assign trial_ge = (trial >= {1'b0, r_new});

  assign acc_s_next = {acc_s[DATA_WIDTH-2:0], 1'b0} + (qbit ? s_new : '0);
  assign acc_t_next = {acc_t[DATA_WIDTH-2:0], 1'b0} + (qbit ? t_new : '0);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r_old <= request.operand_a;
      r_new <= request.operand_b;
      s_old <= {{(DATA_WIDTH-1){1'b0}}, 1'b1};
      s_new <= '0;
      t_old <= '0;
      t_new <= {{(DATA_WIDTH-1){1'b0}}, 1'b1};
      steps <= '0;
    end
    if (cmd.div_init) begin
      rem     <= '0;
      dvd     <= r_old;
      qbit    <= 1'b0;
      bit_cnt <= '0;
      acc_s   <= '0;
      acc_t   <= '0;
    end
    if (cmd.div_step) begin
      rem     <= trial_ge ? diff[OPND_W-1:0] : trial[OPND_W-1:0];
      dvd     <= {dvd[OPND_W-2:0], 1'b0};
      qbit    <= trial_ge;
      bit_cnt <= bit_cnt + 1'b1;
      acc_s   <= acc_s_next;
      acc_t   <= acc_t_next;
    end
    if (cmd.accum) begin
      acc_s <= acc_s_next;
      acc_t <= acc_t_next;
    end
    if (cmd.update) begin
      r_old <= r_new;
      r_new <= rem;
      s_old <= s_new;
      s_new <= s_old - acc_s;
      t_old <= t_new;
      t_new <= t_old - acc_t;
      steps <= steps + 1'b1;
    end
  end

  assign status.rem_le_one = (r_new[OPND_W-1:1] == '0);
  assign status.div_last   = (bit_cnt == BIT_CNT_W'(OPND_W - 1));

  assign result.final_remainder    = r_new;
  assign result.previous_remainder = r_old;
  assign result.step_count         = steps;

  if (DATA_WIDTH >= COEF_OUT_W) begin : g_coef_trunc
    assign result.coeff_s = s_new[COEF_OUT_W-1:0];
    assign result.coeff_t = t_new[COEF_OUT_W-1:0];
  end else begin : g_coef_ext
    assign result.coeff_s = {{(COEF_OUT_W-DATA_WIDTH){1'b0}}, s_new};
    assign result.coeff_t = {{(COEF_OUT_W-DATA_WIDTH){1'b0}}, t_new};
  end

endmodule

>>> rtl/extended_euclid_inverse.sv
// ----------------------------------------------------------------------------
// extended_euclid_inverse
// Extended Euclidean recurrence on two 31-bit operands. The result holds the
// last two remainders, the newest s and t coefficients and the step count;
// a final remainder of one makes coeff_s the inverse of operand_a modulo
// operand_b.
// ----------------------------------------------------------------------------
// An item is taken when start is high while busy is low. Its result appears
// on the result port for a single cycle, marked by done, and the receiver
// cannot stall it, so it must capture the result in that cycle. Busy drops
// in the cycle after done; the block takes no new item until then. Each
// Euclid step passes through the loop check, the bit-serial divider, a
// state that finishes the quotient products and the pair update. With
// 31-bit operands the number of Euclid steps stays below about 46.
module extended_euclid_inverse (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  eei_pkg::eei_request_t request,
  output logic                  busy,
  output logic                  done,
  output eei_pkg::eei_result_t  result
);
  import eei_pkg::*;

  eei_cmd_t    cmd;
  eei_status_t status;

  eei_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  eei_datapath u_datapath (
    .clk     (clk),
    .request (request),
    .cmd     (cmd),
    .status  (status),
    .result  (result)
  );

endmodule

>>> tb/tb_extended_euclid_inverse.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_extended_euclid_inverse
// Self-checking bench for the extended Euclidean inverse block. Directed
// operand pairs hit zero and one operands, full-scale values, swapped order,
// common factors and the longest Fibonacci chain. Random pairs of mixed
// magnitude follow, with random idle gaps on the request side. Every result
// is checked field by field against a bit-accurate recurrence in the bench.
// ----------------------------------------------------------------------------
module tb_extended_euclid_inverse;
  import eei_pkg::*;

  localparam logic [OPND_W-1:0] OPND_MAX   = '1;
  localparam int                RANDOM_CNT = 351;
  localparam logic [OPND_W-1:0] FIB_46     = 31'd1836311903;
  localparam logic [OPND_W-1:0] FIB_45     = 31'd1134903170;

  class inverse_ledger;
    eei_result_t awaited_results[$];
    int unsigned mismatches;
    int unsigned results_seen;
    int unsigned coprime_seen;
    int unsigned max_steps;

    function new();
      mismatches   = 0;
      results_seen = 0;
      coprime_seen = 0;
      max_steps    = 0;
    endfunction

    function eei_result_t run_euclid(eei_request_t req);
      logic [63:0] r_old, r_new, s_old, s_new, t_old, t_new;
      logic [63:0] quo, nxt, cmask;
      logic [31:0] steps;
      eei_result_t res;
      cmask = (DATA_WIDTH >= 64) ? '1 : (64'd1 << DATA_WIDTH) - 64'd1;
      r_old = 64'(req.operand_a);
      r_new = 64'(req.operand_b);
      s_old = 64'd1;
      s_new = 64'd0;
      t_old = 64'd0;
      t_new = 64'd1;
      steps = '0;
      while (r_new > 64'd1) begin
        quo   = r_old / r_new;
        nxt   = r_old - quo * r_new;
        r_old = r_new;
        r_new = nxt;
        nxt   = (s_old - quo * s_new) & cmask;
        s_old = s_new;
        s_new = nxt;
        nxt   = (t_old - quo * t_new) & cmask;
        t_old = t_new;
        t_new = nxt;
        steps = steps + 1;
      end
      res.final_remainder    = r_new[OPND_W-1:0];
      res.previous_remainder = r_old[OPND_W-1:0];
      res.coeff_s            = s_new[COEF_OUT_W-1:0];
      res.coeff_t            = t_new[COEF_OUT_W-1:0];
      res.step_count         = steps[STEP_W-1:0];
      return res;
    endfunction

    function void note_request(eei_request_t req);
      awaited_results.push_back(run_euclid(req));
    endfunction

    function void check_result(eei_result_t got);
      eei_result_t want;
      string bad_fields;
      bad_fields = "";
      results_seen++;
      if (awaited_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] Result with no item outstanding: rem %0d/%0d s %0d t %0d steps %0d",
                   $time, got.final_remainder, got.previous_remainder,
                   $signed(got.coeff_s), $signed(got.coeff_t), got.step_count);
        return;
      end
      want = awaited_results.pop_front();
      if (want.final_remainder == 1) coprime_seen++;
      if (32'(want.step_count) > max_steps) max_steps = 32'(want.step_count);
      if (got.final_remainder !== want.final_remainder)
        bad_fields = {bad_fields, " final_remainder"};
      if (got.previous_remainder !== want.previous_remainder)
        bad_fields = {bad_fields, " previous_remainder"};
      if (got.coeff_s !== want.coeff_s) bad_fields = {bad_fields, " coeff_s"};
      if (got.coeff_t !== want.coeff_t) bad_fields = {bad_fields, " coeff_t"};
      if (got.step_count !== want.step_count) bad_fields = {bad_fields, " step_count"};
      if (bad_fields != "") begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("[%0t] Mismatch in%s", $time, bad_fields);
          $display("  expected: rem %0d/%0d s %0d t %0d steps %0d",
                   want.final_remainder, want.previous_remainder,
                   $signed(want.coeff_s), $signed(want.coeff_t), want.step_count);
          $display("  actual:   rem %0d/%0d s %0d t %0d steps %0d",
                   got.final_remainder, got.previous_remainder,
                   $signed(got.coeff_s), $signed(got.coeff_t), got.step_count);
        end
      end
    endfunction
  endclass

  logic         clk;
  logic         rst;
  logic         start;
  eei_request_t request;
  logic         busy;
  logic         done;
  eei_result_t  result;

  inverse_ledger ledger;
  int unsigned   items_sent;
  int unsigned   directed_cnt;

  extended_euclid_inverse i_dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .request (request),
    .busy    (busy),
    .done    (done),
    .result  (result)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && done) ledger.check_result(result);
  end

  initial begin
    #60ms;
    $display("Timeout with %0d results outstanding.", ledger.awaited_results.size());
    $display("end of test: mismatches");
    $finish;
  end

  task automatic send_item(input logic [OPND_W-1:0] a, input logic [OPND_W-1:0] b,
                           input int unsigned gap);
    eei_request_t req;
    req.operand_a = a;
    req.operand_b = b;
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start   <= 1'b1;
    request <= req;
    do @(posedge clk); while (busy);
    ledger.note_request(req);
    items_sent++;
  endtask

  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (ledger.awaited_results.size() != 0) @(posedge clk);
  endtask

  function automatic int unsigned pick_gap(bit burst);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (burst || roll < 55) return 0;
    if (roll < 95) return $urandom_range(1, 6);
    return $urandom_range(50, 2000);
  endfunction

  function automatic logic [OPND_W-1:0] pick_operand();
    logic [OPND_W-1:0] full;
    full = OPND_W'($urandom);
    return full >> $urandom_range(0, OPND_W - 1);
  endfunction

  task automatic send_random_item(input bit burst);
    logic [OPND_W-1:0] a, b, tmp;
    logic [OPND_W-1:0] factor;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        a = OPND_W'($urandom);
        b = OPND_W'($urandom);
      end
      4: begin
        a = OPND_W'($urandom);
        b = pick_operand();
      end
      5: begin
        factor = OPND_W'($urandom_range(2, 1000));
        a = factor * OPND_W'($urandom_range(1, 1 << 20));
        b = factor * OPND_W'($urandom_range(1, 1 << 20));
      end
      6: begin
        a = pick_operand();
        b = pick_operand();
      end
      7: begin
        a = OPND_W'($urandom_range(0, 40));
        b = OPND_W'($urandom_range(0, 40));
      end
      8: begin
        a = pick_operand();
        b = OPND_W'($urandom);
        if (a > b) begin
          tmp = a;
          a   = b;
          b   = tmp;
        end
      end
      default: begin
        a = OPND_W'($urandom);
        case ($urandom_range(0, 4))
          0:       b = '0;
          1:       b = OPND_W'(1);
          2:       b = a;
          3:       b = OPND_MAX - OPND_W'($urandom_range(0, 3));
          default: b = OPND_W'(1) << $urandom_range(0, OPND_W - 1);
        endcase
      end
    endcase
    send_item(a, b, pick_gap(burst));
  endtask

  initial begin
    ledger     = new();
    items_sent = 0;
    rst        = 1'b1;
    start      = 1'b0;
    request    = '0;
    repeat (9) @(negedge clk);
    rst = 1'b0;

    send_item('0, '0, 0);
    send_item('0, OPND_W'(1), 0);
    send_item(OPND_MAX, '0, 1);
    send_item(OPND_MAX, OPND_W'(1), 0);
    send_item('0, OPND_MAX, 3);
    send_item(OPND_W'(1), OPND_W'(1), 0);
    send_item(OPND_W'(1), OPND_MAX, 0);
    send_item(OPND_MAX, OPND_MAX, 2);
    send_item(OPND_MAX, OPND_MAX - OPND_W'(1), 0);
    send_item(OPND_MAX - OPND_W'(1), OPND_MAX, 0);
    send_item(OPND_W'(3), OPND_W'(7), 0);
    send_item(OPND_W'(7), OPND_W'(3), 5);
    send_item(OPND_W'(12), OPND_W'(18), 0);
    send_item(OPND_W'(240), OPND_W'(46), 0);
    send_item(FIB_46, FIB_45, 0);
    send_item(FIB_45, FIB_46, 1);
    send_item(OPND_W'(1) << 30, (OPND_W'(1) << 30) - OPND_W'(1), 0);
    send_item(OPND_W'(1) << 30, OPND_W'(2), 0);
    send_item(OPND_W'(17), OPND_W'(17), 0);
    directed_cnt = items_sent;

    // Let the block go fully idle before the random part starts.
    drain_results();

    for (int i = 0; i < RANDOM_CNT; i++) begin
      if (i == RANDOM_CNT / 2) drain_results();
      send_random_item((i >= 100 && i < 140) || (i >= 300 && i < 320));
    end

    drain_results();
    repeat (50) @(posedge clk);

    if (ledger.awaited_results.size() != 0) begin
      $display("%0d expected results never arrived.", ledger.awaited_results.size());
      ledger.mismatches += ledger.awaited_results.size();
    end
    $display("Sent %0d items (%0d directed) and checked %0d results.",
             items_sent, directed_cnt, ledger.results_seen);
    $display("%0d pairs were coprime; the longest chain took %0d steps; %0d mismatches.",
             ledger.coprime_seen, ledger.max_steps, ledger.mismatches);
    if (ledger.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
